[rtl/ldsp_pkg.sv]
// Shared constants and types of the lax DER signature parser.
package ldsp_pkg;

  localparam int MAX_SIG_BYTES_DEF = 1024;
  localparam int INT_BYTES_DEF     = 32;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;

  localparam logic [1:0] ST_PARSED   = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  typedef struct packed {
    logic       load;
    logic [1:0] status;
  } done_t;

endpackage

[rtl/lax_der_signature_parser_top.sv]
// Top level of the lax DER ECDSA signature parser.
//
// The input channel carries one request per byte of a DER signature: sig_byte,
// with final_byte set on the last byte. A byte is taken at a rising edge with
// in_valid high and in_stall low. Every byte runs through the parse state
// machine in the cycle it is taken; one byte per cycle flows while not stalled.
// On the final byte the compact R||S buffer and its status are copied into a
// result register, and the parse state returns to its reset values so the
// next signature can start with the very next byte.
// The output channel then sends (2*INT_BYTES+7)/8 words (eight by default),
// word_index counting up from 0 and last_word set on the last one, starting
// the cycle after the final byte is taken. A word moves at an edge with
// out_valid high and out_stall low. A stalled output holds its word and only
// pushes back on the input when a further final byte arrives before the
// previous burst has drained; ordinary bytes keep flowing, and a final byte
// is taken in the same cycle the last word of the burst leaves.
// Words are all zero when parse_status reports overflow or reject.
// A synchronous reset empties the result register and returns the parser
// to the point of expecting a sequence tag with a cleared buffer.
module lax_der_signature_parser_top #(
  parameter int MAX_SIG_BYTES = ldsp_pkg::MAX_SIG_BYTES_DEF,
  parameter int INT_BYTES     = ldsp_pkg::INT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  sig_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  word_index,
  output logic [63:0] compact_word,
  output logic [1:0]  parse_status,
  output logic        last_word
);

  localparam int NUM_WORDS = (2 * INT_BYTES + 7) / 8;

  ldsp_pkg::done_t             done;
  logic [NUM_WORDS*64-1:0]     compact_bytes;
  logic                        burst_free;
  logic                        take;

  // Only a final byte needs the result register, so only it can be held off.
  assign in_stall = final_byte && !burst_free;
  assign take     = in_valid && !in_stall;

  ldsp_parser #(
    .MAX_SIG_BYTES (MAX_SIG_BYTES),
    .INT_BYTES     (INT_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .sig_byte      (sig_byte),
    .final_byte    (final_byte),
    .done          (done),
    .compact_bytes (compact_bytes)
  );

  ldsp_burst #(
    .INT_BYTES (INT_BYTES)
  ) u_burst (
    .clk           (clk),
    .rst           (rst),
    .done          (done),
    .compact_bytes (compact_bytes),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .word_index    (word_index),
    .compact_word  (compact_word),
    .parse_status  (parse_status),
    .last_word     (last_word),
    .free          (burst_free)
  );

endmodule

[rtl/ldsp_parser.sv]
// Byte-wide DER parse state machine and the compact R||S byte buffer.
module ldsp_parser #(
  parameter int MAX_SIG_BYTES = ldsp_pkg::MAX_SIG_BYTES_DEF,
  parameter int INT_BYTES     = ldsp_pkg::INT_BYTES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        take,
  input  logic [7:0]                                  sig_byte,
  input  logic                                        final_byte,
  output ldsp_pkg::done_t                             done,
  output logic [((2 * INT_BYTES + 7) / 8) * 64 - 1:0] compact_bytes
);

  localparam int NUM_WORDS = (2 * INT_BYTES + 7) / 8;
  localparam int PAD_BYTES = NUM_WORDS * 8;
  localparam int LVW       = $clog2(MAX_SIG_BYTES + 2);
  localparam int SCW       = $clog2(INT_BYTES + 2);
  localparam logic [LVW-1:0] LV_SAT = LVW'(MAX_SIG_BYTES + 1);

  localparam logic [3:0] PH_SEQ_TAG  = 4'd0;
  localparam logic [3:0] PH_SEQ_LEN  = 4'd1;
  localparam logic [3:0] PH_SEQ_SKIP = 4'd2;
  localparam logic [3:0] PH_R_TAG    = 4'd3;
  localparam logic [3:0] PH_R_LEN    = 4'd4;
  localparam logic [3:0] PH_R_LLEN   = 4'd5;
  localparam logic [3:0] PH_R_DATA   = 4'd6;
  localparam logic [3:0] PH_S_TAG    = 4'd7;
  localparam logic [3:0] PH_S_LEN    = 4'd8;
  localparam logic [3:0] PH_S_LLEN   = 4'd9;
  localparam logic [3:0] PH_S_DATA   = 4'd10;
  localparam logic [3:0] PH_DONE     = 4'd11;

  logic [3:0]     parse_phase, parse_phase_next;
  logic [6:0]     length_bytes_left, length_bytes_left_next;
  logic [LVW-1:0] length_value, length_value_next;
  logic [LVW-1:0] content_left, content_left_next;
  logic [SCW-1:0] significant_count, significant_count_next;
  logic [7:0]     r_bytes [INT_BYTES];
  logic [7:0]     r_bytes_next [INT_BYTES];
  logic [7:0]     s_bytes [INT_BYTES];
  logic [7:0]     s_bytes_next [INT_BYTES];
  logic           overflow_flag, overflow_flag_next;
  logic           reject_flag, reject_flag_next;

  logic           is_s;
  logic [3:0]     tag_phase;
  logic           do_fin;
  logic           do_end;
  logic [LVW-1:0] fin_len;
  logic [LVW-1:0] short_len;
  logic [LVW-1:0] long_len;
  logic [LVW+7:0] lv_wide;
  logic           rej_final;
  logic [1:0]     status;

  assign is_s      = parse_phase >= PH_S_TAG;
  assign tag_phase = is_s ? PH_S_TAG : PH_R_TAG;
  assign lv_wide   = {length_value, sig_byte};
  assign short_len = (32'(sig_byte) > 32'(MAX_SIG_BYTES)) ? LV_SAT : LVW'(sig_byte);
  assign long_len  = (32'(lv_wide) > 32'(MAX_SIG_BYTES)) ? LV_SAT : LVW'(lv_wide);

  always_comb begin
    parse_phase_next       = parse_phase;
    length_bytes_left_next = length_bytes_left;
    length_value_next      = length_value;
    content_left_next      = content_left;
    significant_count_next = significant_count;
    r_bytes_next           = r_bytes;
    s_bytes_next           = s_bytes;
    overflow_flag_next     = overflow_flag;
    reject_flag_next       = reject_flag;
    do_fin                 = 1'b0;
    do_end                 = 1'b0;
    fin_len                = '0;

    unique case (parse_phase) inside
      PH_SEQ_TAG: begin
        if (sig_byte != ldsp_pkg::TAG_SEQUENCE) begin
          reject_flag_next = 1'b1;
          parse_phase_next = PH_DONE;
        end else begin
          parse_phase_next = PH_SEQ_LEN;
        end
      end
      PH_SEQ_LEN: begin
        if (sig_byte[7] && (sig_byte[6:0] != 7'd0)) begin
          length_bytes_left_next = sig_byte[6:0];
          parse_phase_next       = PH_SEQ_SKIP;
        end else begin
          parse_phase_next = PH_R_TAG;
        end
      end
      PH_SEQ_SKIP: begin
        if (length_bytes_left != 7'd0) length_bytes_left_next = length_bytes_left - 7'd1;
        if (length_bytes_left_next == 7'd0) parse_phase_next = PH_R_TAG;
      end
      PH_R_TAG, PH_S_TAG: begin
        if (sig_byte != ldsp_pkg::TAG_INTEGER) begin
          reject_flag_next = 1'b1;
          parse_phase_next = PH_DONE;
        end else begin
          parse_phase_next = tag_phase + 4'd1;
        end
      end
      PH_R_LEN, PH_S_LEN: begin
        length_value_next = '0;
        if (sig_byte[7]) begin
          length_bytes_left_next = sig_byte[6:0];
          if (sig_byte[6:0] == 7'd0) begin
            do_fin = 1'b1;
          end else begin
            parse_phase_next = tag_phase + 4'd2;
          end
        end else begin
          length_value_next = short_len;
          do_fin            = 1'b1;
          fin_len           = short_len;
        end
      end
      PH_R_LLEN, PH_S_LLEN: begin
        // Too many length bytes left after the leading zeros: reject.
        if ((length_value == '0) && (sig_byte != 8'd0) && (length_bytes_left >= 7'd8)) begin
          reject_flag_next = 1'b1;
          parse_phase_next = PH_DONE;
        end else begin
          if ((length_value != '0) || (sig_byte != 8'd0)) length_value_next = long_len;
          if (length_bytes_left != 7'd0) length_bytes_left_next = length_bytes_left - 7'd1;
          if (length_bytes_left_next == 7'd0) begin
            do_fin  = 1'b1;
            fin_len = length_value_next;
          end
        end
      end
      PH_R_DATA, PH_S_DATA: begin
        if ((significant_count != '0) || (sig_byte != 8'd0)) begin
          if (significant_count < SCW'(INT_BYTES)) begin
            for (int k = 0; k < INT_BYTES - 1; k++) begin
              if (is_s) s_bytes_next[k] = s_bytes[k+1];
              else      r_bytes_next[k] = r_bytes[k+1];
            end
            if (is_s) s_bytes_next[INT_BYTES-1] = sig_byte;
            else      r_bytes_next[INT_BYTES-1] = sig_byte;
            significant_count_next = significant_count + SCW'(1);
          end else begin
            significant_count_next = SCW'(INT_BYTES + 1);
            overflow_flag_next     = 1'b1;
          end
        end
        if (content_left != '0) content_left_next = content_left - LVW'(1);
        if (content_left_next == '0) do_end = 1'b1;
      end
      PH_DONE: begin
      end
      default: begin
        reject_flag_next = 1'b1;
        parse_phase_next = PH_DONE;
      end
    endcase

    if (do_fin) begin
      if (fin_len == LV_SAT) begin
        reject_flag_next = 1'b1;
        parse_phase_next = PH_DONE;
      end else if (fin_len == '0) begin
        do_end = 1'b1;
      end else begin
        content_left_next = fin_len;
        parse_phase_next  = tag_phase + 4'd3;
      end
    end

    if (do_end) begin
      parse_phase_next       = is_s ? PH_DONE : PH_S_TAG;
      significant_count_next = '0;
    end
  end

  // A final byte that leaves the parse short of the end of S rejects.
  assign rej_final = reject_flag_next || (parse_phase_next != PH_DONE);
  assign status    = rej_final ? ldsp_pkg::ST_REJECTED :
                     (overflow_flag_next ? ldsp_pkg::ST_OVERFLOW : ldsp_pkg::ST_PARSED);

  assign done.load   = take && final_byte;
  assign done.status = status;

  for (genvar k = 0; k < PAD_BYTES; k++) begin : g_pack
    if (k < INT_BYTES) begin : g_r
      assign compact_bytes[(PAD_BYTES-1-k)*8 +: 8] =
        (status == ldsp_pkg::ST_PARSED) ? r_bytes_next[k] : 8'd0;
    end else if (k < 2 * INT_BYTES) begin : g_s
      assign compact_bytes[(PAD_BYTES-1-k)*8 +: 8] =
        (status == ldsp_pkg::ST_PARSED) ? s_bytes_next[k-INT_BYTES] : 8'd0;
    end else begin : g_pad
      assign compact_bytes[(PAD_BYTES-1-k)*8 +: 8] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && final_byte)) begin
      parse_phase       <= PH_SEQ_TAG;
      length_bytes_left <= '0;
      length_value      <= '0;
      content_left      <= '0;
      significant_count <= '0;
      r_bytes           <= '{default: '0};
      s_bytes           <= '{default: '0};
      overflow_flag     <= 1'b0;
      reject_flag       <= 1'b0;
    end else if (take) begin
      parse_phase       <= parse_phase_next;
      length_bytes_left <= length_bytes_left_next;
      length_value      <= length_value_next;
      content_left      <= content_left_next;
      significant_count <= significant_count_next;
      r_bytes           <= r_bytes_next;
      s_bytes           <= s_bytes_next;
      overflow_flag     <= overflow_flag_next;
      reject_flag       <= reject_flag_next;
    end
  end

endmodule

[rtl/ldsp_burst.sv]
// Result register that holds a finished signature and sends it out word by word.
module ldsp_burst #(
  parameter int INT_BYTES = ldsp_pkg::INT_BYTES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  ldsp_pkg::done_t                             done,
  input  logic [((2 * INT_BYTES + 7) / 8) * 64 - 1:0] compact_bytes,
  input  logic                                        out_stall,
  output logic                                        out_valid,
  output logic [2:0]                                  word_index,
  output logic [63:0]                                 compact_word,
  output logic [1:0]                                  parse_status,
  output logic                                        last_word,
  output logic                                        free
);

  localparam int NUM_WORDS = (2 * INT_BYTES + 7) / 8;
  localparam int CNTW      = $clog2(NUM_WORDS);

  logic [63:0]     words [NUM_WORDS];
  logic [CNTW-1:0] count;
  logic [1:0]      status;
  logic            valid;
  logic            take_out;
  logic            at_last;

  assign at_last  = count == CNTW'(NUM_WORDS - 1);
  assign take_out = valid && !out_stall;
  // Room for a new burst once the last word of the current one leaves.
  assign free     = !valid || (take_out && at_last);

  assign out_valid    = valid;
  assign word_index   = 3'(count);
  assign compact_word = words[0];
  assign parse_status = status;
  assign last_word    = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (done.load) begin
      valid <= 1'b1;
      count <= '0;
    end else if (take_out) begin
      if (at_last) valid <= 1'b0;
      else         count <= count + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (done.load) begin
      status <= done.status;
      for (int i = 0; i < NUM_WORDS; i++) begin
        words[i] <= compact_bytes[(NUM_WORDS-1-i)*64 +: 64];
      end
    end else if (take_out) begin
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

endmodule

[rtl/ldsp_checker.sv]
// Port-level checks of the signature parser top and their bind.
module ldsp_checker #(
  parameter int INT_BYTES = ldsp_pkg::INT_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  word_index,
  input logic [63:0] compact_word,
  input logic [1:0]  parse_status,
  input logic        last_word
);

  localparam int NUM_WORDS = (2 * INT_BYTES + 7) / 8;

  // A failed or overflowed signature never leaks buffer contents.
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (parse_status != ldsp_pkg::ST_PARSED) |-> compact_word == 64'd0)
    else $error("nonzero word with error status");

  // Within a burst the words follow each other without a gap.
  a_burst_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=>
      out_valid && (word_index == 3'($past(word_index) + 3'd1)) && $stable(parse_status))
    else $error("burst broken");

  // A burst after the last word starts again at word zero.
  a_burst_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=> !out_valid || (word_index == 3'd0))
    else $error("new burst does not start at word zero");

  // last_word marks exactly the final word position.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'(NUM_WORDS - 1))))
    else $error("last_word at wrong position");

  // With the result register empty, no byte is held off.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind lax_der_signature_parser_top ldsp_checker #(.INT_BYTES(INT_BYTES)) u_ldsp_checker (.*);
